// ===== src/bfr_pkg.sv =====
package bfr_pkg;

    // frame buffer sizing
    localparam int FRAME_CAPACITY = 16;
    localparam int ADDR_W         = $clog2(FRAME_CAPACITY);
    localparam int CNT_W          = $clog2(FRAME_CAPACITY + 1);

    // field widths
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 4;
    localparam int LEN_W   = 4;
    localparam int TDATA_W = 16;
    localparam int PAD_W   = TDATA_W - BYTE_W - IDX_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE  = 2'd2;

    // register reset values
    localparam logic [BYTE_W-1:0] ACK_CODE_RST   = 8'hA5;
    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'hA8;
    localparam logic [BYTE_W-1:0] STOP_CODE_RST  = 8'hA3;

    // command codes that select the long frame
    localparam logic [BYTE_W-1:0] CMD_LONG_A = 8'hEC;
    localparam logic [BYTE_W-1:0] CMD_LONG_B = 8'hD2;
    localparam logic [BYTE_W-1:0] CMD_LONG_C = 8'hD1;

    // minimum byte count before a stop byte may close the frame
    localparam logic [LEN_W-1:0] LEN_LONG  = 4'd10;
    localparam logic [LEN_W-1:0] LEN_SHORT = 4'd6;

    // request from the framing logic to the readout sequencer
    typedef struct packed {
        logic              start;
        logic              ack;
        logic [BYTE_W-1:0] ack_byte;
        logic [ADDR_W-1:0] last_idx;
    } t_emit_req;

    function automatic logic [LEN_W-1:0] len_for_code(input logic [BYTE_W-1:0] code);
        logic long_frame;
        long_frame = (code == CMD_LONG_A) || (code == CMD_LONG_B) || (code == CMD_LONG_C);
        return long_frame ? LEN_LONG : LEN_SHORT;
    endfunction

endpackage

// ===== src/bfr_store.sv =====
module bfr_store (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [bfr_pkg::ADDR_W-1:0]    i_wr_addr,
    input  logic [bfr_pkg::BYTE_W-1:0]    i_wr_data,
    input  logic                          i_rd_en,
    input  logic [bfr_pkg::ADDR_W-1:0]    i_rd_addr,
    output logic [bfr_pkg::BYTE_W-1:0]    o_rd_data
);
    import bfr_pkg::*;

    logic [BYTE_W-1:0] r_mem [FRAME_CAPACITY];
    logic [BYTE_W-1:0] r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/bfr_emit.sv =====
module bfr_emit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bfr_pkg::t_emit_req             i_req,
    output logic                           o_idle,
    output logic                           o_rd_en,
    output logic [bfr_pkg::ADDR_W-1:0]     o_rd_addr,
    input  logic [bfr_pkg::BYTE_W-1:0]     i_rd_data,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [bfr_pkg::TDATA_W-1:0]    o_m_tdata,  // frame_byte[7:0], byte_index[11:8], zero
    output logic                           o_m_tuser,  // is_ack
    output logic                           o_m_tlast
);
    import bfr_pkg::*;

    typedef enum logic [2:0] {
        E_IDLE = 3'b001,
        E_READ = 3'b010,
        E_SHOW = 3'b100
    } t_emit_state;

    t_emit_state       r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_last_idx, n_last_idx;
    logic              r_ack, n_ack;
    logic [BYTE_W-1:0] r_ack_byte, n_ack_byte;
    logic              out_last;
    logic [BYTE_W-1:0] out_byte;

    assign out_last = r_ack || (r_idx == r_last_idx);
    assign out_byte = r_ack ? r_ack_byte : i_rd_data;

    // readout sequencer: fetch each stored byte (an ack byte needs no fetch), then hold it until taken
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        n_ack      = r_ack;
        n_ack_byte = r_ack_byte;
        unique case (r_state)
            E_IDLE: begin
                if (i_req.start) begin
                    n_idx      = '0;
                    n_last_idx = i_req.ack ? '0 : i_req.last_idx;
                    n_ack      = i_req.ack;
                    n_ack_byte = i_req.ack_byte;
                    n_state    = i_req.ack ? E_SHOW : E_READ;
                end
            end
            E_READ: begin
                n_state = E_SHOW;
            end
            E_SHOW: begin
                if (i_m_tready) begin
                    if (out_last) begin
                        n_state = E_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = E_READ;
                    end
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_ack   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ack   <= n_ack;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_ack_byte <= n_ack_byte;
    end

    assign o_idle     = (r_state == E_IDLE);
    assign o_rd_en    = (r_state == E_READ);
    assign o_rd_addr  = r_idx;
    assign o_m_tvalid = (r_state == E_SHOW);
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_idx[IDX_W-1:0], out_byte};
    assign o_m_tuser  = r_ack;
    assign o_m_tlast  = out_last;

endmodule

// ===== src/bus_frame_receiver_unit.sv =====
// Start/stop framed receiver with an XOR checksum. Each received byte is taken while the
// output side is idle. While idle, an ack byte comes straight out as a one-byte frame with tuser set;
// a start byte opens a frame and other idle bytes are dropped. The byte after the start
// sets the minimum length (10 for commands EC, D2, D1, else 6); a stop byte at or past
// it closes the frame, which is sent start byte first if the XOR of bytes 1 up to three
// before the end equals the byte before the stop. A frame that overruns the 16-byte
// buffer is dropped. Sending a frame reads the buffer through its single read port,
// fetching each byte (E_READ) before showing it (E_SHOW), so the input stays stalled until
// the last byte is taken, output backpressure included; an ack holds it until it is taken.
module bus_frame_receiver_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [bfr_pkg::BYTE_W-1:0]       i_s_tdata,   // rx_byte[7:0]
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [bfr_pkg::TDATA_W-1:0]      o_m_tdata,   // frame_byte[7:0], byte_index[11:8]
    output logic                             o_m_tuser,   // is_ack
    output logic                             o_m_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bfr_pkg::BYTE_W-1:0]       i_cfg_data
);
    import bfr_pkg::*;

    logic [BYTE_W-1:0] r_ack_code, r_start_code, r_stop_code;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [LEN_W-1:0]  r_exp, n_exp;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              emit_idle;
    logic              in_req;
    logic [BYTE_W-1:0] rx_byte;
    logic [CNT_W-1:0]  fill_inc;
    logic [LEN_W-1:0]  exp_sel;
    t_emit_req         req;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = emit_idle;
    assign in_req      = i_s_tvalid && o_s_tready;
    assign rx_byte     = i_s_tdata;
    assign fill_inc    = r_fill + 1'b1;
    assign exp_sel     = (r_exp == '0) ? len_for_code(rx_byte) : r_exp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_code   <= ACK_CODE_RST;
            r_start_code <= START_CODE_RST;
            r_stop_code  <= STOP_CODE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ACK_CODE:   r_ack_code   <= i_cfg_data;
                REG_START_CODE: r_start_code <= i_cfg_data;
                REG_STOP_CODE:  r_stop_code  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // framing: sort each byte into ack, frame open, frame data, close or drop
    always_comb begin
        n_fill       = r_fill;
        n_exp        = r_exp;
        n_xor        = r_xor;
        wr_en        = 1'b0;
        wr_addr      = r_fill[ADDR_W-1:0];
        req.start    = 1'b0;
        req.ack      = 1'b0;
        req.ack_byte = rx_byte;
        req.last_idx = r_fill[ADDR_W-1:0];
        if (in_req) begin
            priority if (r_fill == '0) begin
                // idle: ack wins over start when both codes match
                if (rx_byte == r_ack_code) begin
                    req.start = 1'b1;
                    req.ack   = 1'b1;
                end else if (rx_byte == r_start_code) begin
                    wr_en  = 1'b1;
                    n_fill = CNT_W'(1);
                    n_exp  = '0;
                    n_xor  = '0;
                end
            end else if (r_fill >= CNT_W'(FRAME_CAPACITY)) begin
                // overrun: drop the frame
                n_fill = '0;
                n_exp  = '0;
                n_xor  = '0;
            end else begin
                wr_en  = 1'b1;
                n_fill = fill_inc;
                n_exp  = exp_sel;
                n_xor  = r_xor ^ rx_byte;
                if ((fill_inc >= CNT_W'(exp_sel)) && (rx_byte == r_stop_code)) begin
                    // r_xor covers bytes 1 up to the checksum, so a match leaves zero
                    req.start = (r_xor == '0);
                    n_fill    = '0;
                    n_exp     = '0;
                    n_xor     = '0;
                end
            end
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_exp  <= '0;
            r_xor  <= '0;
        end else begin
            r_fill <= n_fill;
            r_exp  <= n_exp;
            r_xor  <= n_xor;
        end
    end

    bfr_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bfr_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_idle     (emit_idle),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // input is held off while a frame is being sent
    a_no_input_while_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while output valid");

    // fill count stays within the buffer
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(FRAME_CAPACITY))
        else $error("fill count past capacity");

    // once past the command byte the minimum length is known
    a_len_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill >= CNT_W'(2)) |-> (r_exp != '0))
        else $error("minimum length unset inside frame");

    // after the last byte is taken the input side reopens
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("input not reopened after frame end");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import bfr_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_GAP       = 13;

    // one output byte as seen on the master side
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic              ack;
        logic              last;
    } t_out_byte;

    // one received byte plus the idle cycles in front of it
    typedef struct {
        logic [BYTE_W-1:0] data;
        int                gap;
    } t_rx_item;

    typedef enum int {FR_GOOD, FR_BAD_SUM, FR_EARLY_STOP, FR_ACK_INSIDE} t_frame_kind;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [BYTE_W-1:0]    s_tdata   = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ACK_CODE;
    logic [BYTE_W-1:0]    cfg_data  = '0;

    bus_frame_receiver_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // framer copy: codes, buffer, fill level, length and checksum
    logic [BYTE_W-1:0] cur_ack   = ACK_CODE_RST;
    logic [BYTE_W-1:0] cur_start = START_CODE_RST;
    logic [BYTE_W-1:0] cur_stop  = STOP_CODE_RST;
    logic [BYTE_W-1:0] pred_store [FRAME_CAPACITY];
    int                pred_fill    = 0;
    int                pred_min_len = 0;
    logic [BYTE_W-1:0] pred_xor     = '0;

    t_out_byte predicted_q[$];
    t_out_byte received_q[$];
    t_rx_item  rx_q[$];

    int mismatches    = 0;
    int counted_bytes = 0;

    // minimum length set by the command byte
    function automatic int frame_min_len(input logic [BYTE_W-1:0] cmd);
        if (cmd == CMD_LONG_A || cmd == CMD_LONG_B || cmd == CMD_LONG_C)
            return int'(LEN_LONG);
        return int'(LEN_SHORT);
    endfunction

    // advance the framer copy by one byte, queue any bytes it sends out
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] sum;
        t_out_byte         ob;
        if (pred_fill == 0) begin
            if (b == cur_ack) begin
                ob.data = b;
                ob.idx  = '0;
                ob.ack  = 1'b1;
                ob.last = 1'b1;
                predicted_q.push_back(ob);
            end else if (b == cur_start) begin
                pred_store[0] = b;
                pred_fill     = 1;
                pred_min_len  = 0;
                pred_xor      = '0;
            end
        end else if (pred_fill >= FRAME_CAPACITY) begin
            // overrun: frame thrown away, back to idle
            pred_fill    = 0;
            pred_min_len = 0;
            pred_xor     = '0;
        end else begin
            if (pred_min_len == 0)
                pred_min_len = frame_min_len(b);
            pred_store[pred_fill] = b;
            pred_fill++;
            pred_xor ^= b;
            if (pred_fill >= pred_min_len && b == cur_stop && pred_fill >= 3) begin
                // checksum covers bytes 1 up to three before the end
                sum = pred_xor ^ pred_store[pred_fill-1] ^ pred_store[pred_fill-2];
                if (sum == pred_store[pred_fill-2]) begin
                    for (int i = 0; i < pred_fill; i++) begin
                        ob.data = pred_store[i];
                        ob.idx  = IDX_W'(i);
                        ob.ack  = 1'b0;
                        ob.last = (i + 1 == pred_fill);
                        predicted_q.push_back(ob);
                    end
                end
                pred_fill    = 0;
                pred_min_len = 0;
                pred_xor     = '0;
            end
        end
    endfunction

    // sender: stages the next byte, honors its gap, predicts on accept
    t_rx_item staged;
    logic     have_staged = 1'b0;
    int       gap_left    = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid    <= 1'b0;
            have_staged = 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (!have_staged && rx_q.size() > 0) begin
                    staged      = rx_q.pop_front();
                    have_staged = 1'b1;
                    gap_left    = staged.gap;
                end
                if (have_staged && gap_left == 0) begin
                    s_tdata     <= staged.data;
                    s_tvalid    <= 1'b1;
                    have_staged = 1'b0;
                end else begin
                    if (have_staged)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    always @(posedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: capture accepted bytes, stall in random stretches
    int   stall_left     = 0;
    logic stalls_on      = 1'b1;
    int   recv_mode_left = 0;

    always @(posedge clk) begin
        t_out_byte got;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.data = m_tdata[BYTE_W-1:0];
                got.idx  = m_tdata[BYTE_W +: IDX_W];
                got.ack  = m_tuser;
                got.last = m_tlast;
                received_q.push_back(got);
                if (recv_mode_left == 0) begin
                    stalls_on      = ($urandom_range(0, 2) != 0);
                    recv_mode_left = $urandom_range(10, 60);
                end
                recv_mode_left--;
                stall_left = stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_tready <= (hold_left == 0 && stall_left == 0);
        end
    end

    // compare captured bytes against predictions on the falling edge
    always @(negedge clk) begin
        t_out_byte got;
        t_out_byte want;
        while (received_q.size() > 0) begin
            got = received_q.pop_front();
            if (predicted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: byte %h idx %0d ack %b last %b",
                             got.data, got.idx, got.ack, got.last);
            end else begin
                want = predicted_q.pop_front();
                if (got.data !== want.data || got.idx !== want.idx ||
                    got.ack !== want.ack || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp byte %h idx %0d ack %b last %b, ",
                                  "got byte %h idx %0d ack %b last %b"},
                                 want.data, want.idx, want.ack, want.last,
                                 got.data, got.idx, got.ack, got.last);
                end
            end
        end
    end

    // run limit
    int cycle_count = 0;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // sender gaps come in stretches, some with no idling at all
    logic send_gaps_on   = 1'b1;
    int   send_mode_left = 0;

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic counts);
        t_rx_item it;
        if (send_mode_left == 0) begin
            send_gaps_on   = ($urandom_range(0, 2) != 0);
            send_mode_left = $urandom_range(8, 40);
        end
        send_mode_left--;
        it.data = b;
        it.gap  = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        rx_q.push_back(it);
        if (counts)
            counted_bytes++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_cmd(input logic long_one);
        logic [BYTE_W-1:0] c;
        if (long_one) begin
            case ($urandom_range(0, 2))
                0:       c = CMD_LONG_A;
                1:       c = CMD_LONG_B;
                default: c = CMD_LONG_C;
            endcase
        end else begin
            do c = BYTE_W'($urandom); while (frame_min_len(c) == int'(LEN_LONG));
        end
        return c;
    endfunction

    // mostly short frames, now and then up to the full buffer
    function automatic int pick_len(input int min_len);
        if ($urandom_range(0, 9) < 7)
            return min_len + $urandom_range(0, 2);
        return $urandom_range(min_len, FRAME_CAPACITY);
    endfunction

    function automatic logic [BYTE_W-1:0] non_stop_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom); while (b == cur_stop);
        return b;
    endfunction

    // start, command, payload, checksum, stop
    task automatic queue_frame(input logic [BYTE_W-1:0] cmd, input int n,
                               input t_frame_kind kind);
        logic [BYTE_W-1:0] fb [FRAME_CAPACITY];
        logic [BYTE_W-1:0] sum;
        int                min_len;
        int                k;
        min_len = frame_min_len(cmd);
        fb[0] = cur_start;
        fb[1] = cmd;
        for (k = 2; k < n - 2; k++)
            fb[k] = non_stop_byte();
        if (kind == FR_EARLY_STOP) begin
            // stop code too early to close, kept as data
            k = $urandom_range(2, (min_len - 2 < n - 3) ? min_len - 2 : n - 3);
            fb[k] = cur_stop;
        end else if (kind == FR_ACK_INSIDE) begin
            fb[$urandom_range(2, n - 3)] = cur_ack;
        end
        sum = '0;
        for (k = 1; k < n - 2; k++)
            sum ^= fb[k];
        if (kind == FR_BAD_SUM)
            sum ^= BYTE_W'($urandom_range(1, 255));
        fb[n-2] = sum;
        fb[n-1] = cur_stop;
        for (k = 0; k < n; k++)
            push_byte(fb[k], 1'b1);
    endtask

    // wait for the sender to empty and every predicted byte to arrive
    task automatic drain_outputs();
        @(negedge clk);
        while (rx_q.size() != 0 || have_staged || s_tvalid || predicted_q.size() != 0)
            @(negedge clk);
    endtask

    // close any open frame by overrunning it, then let the block settle
    task automatic settle_idle();
        drain_outputs();
        while (pred_fill != 0) begin
            push_byte(cur_stop ^ 8'h01, 1'b0);
            drain_outputs();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ACK_CODE:   cur_ack   = val;
            REG_START_CODE: cur_start = val;
            REG_STOP_CODE:  cur_stop  = val;
            default: ;
        endcase
    endtask

    // random mix of good frames, broken frames, acks and line noise
    task automatic add_random(input int budget);
        int                stop_at;
        int                mid;
        logic              paused;
        int                r;
        int                k;
        logic [BYTE_W-1:0] cmd;
        stop_at = counted_bytes + budget;
        mid     = counted_bytes + budget / 2;
        paused  = 1'b0;
        while (counted_bytes < stop_at) begin
            if (!paused && counted_bytes >= mid) begin
                drain_outputs();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 50) begin
                cmd = pick_cmd($urandom_range(0, 2) == 0);
                queue_frame(cmd, pick_len(frame_min_len(cmd)), FR_GOOD);
            end else if (r < 58) begin
                cmd = pick_cmd($urandom_range(0, 2) == 0);
                queue_frame(cmd, pick_len(frame_min_len(cmd)), FR_BAD_SUM);
            end else if (r < 64) begin
                cmd = pick_cmd($urandom_range(0, 2) == 0);
                queue_frame(cmd, pick_len(frame_min_len(cmd)), FR_EARLY_STOP);
            end else if (r < 70) begin
                cmd = pick_cmd($urandom_range(0, 2) == 0);
                queue_frame(cmd, pick_len(frame_min_len(cmd)), FR_ACK_INSIDE);
            end else if (r < 76) begin
                push_byte(cur_ack, 1'b1);
            end else if (r < 82) begin
                // overrun: fill the buffer and send one more
                push_byte(cur_start, 1'b1);
                for (k = 0; k < FRAME_CAPACITY; k++)
                    push_byte(non_stop_byte(), 1'b1);
            end else if (r < 88) begin
                for (k = $urandom_range(1, 3); k > 0; k--)
                    push_byte(BYTE_W'($urandom), 1'b0);
            end else if (r < 94) begin
                // frame cut short, whatever follows lands inside it
                push_byte(cur_start, 1'b1);
                for (k = $urandom_range(1, 4); k > 0; k--)
                    push_byte(BYTE_W'($urandom), 1'b1);
            end else begin
                queue_frame(pick_cmd($urandom_range(0, 1) == 0), FRAME_CAPACITY, FR_GOOD);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // lone ack, stray extremes, minimal short frame with 00/FF payload
        push_byte(ACK_CODE_RST, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(START_CODE_RST, 1'b1);
        push_byte(8'h01, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFE, 1'b1);
        push_byte(STOP_CODE_RST, 1'b1);
        // minimal long frame, then a short one with a bad checksum
        queue_frame(CMD_LONG_A, int'(LEN_LONG), FR_GOOD);
        queue_frame(8'h01, int'(LEN_SHORT), FR_BAD_SUM);
        add_random(70);
        settle_idle();

        write_reg(REG_ACK_CODE, 8'h00);
        write_reg(REG_START_CODE, 8'hFF);
        write_reg(REG_STOP_CODE, 8'h80);
        add_random(70);
        settle_idle();

        // ack and start share a code, ack wins while idle
        write_reg(REG_ACK_CODE, 8'h5A);
        write_reg(REG_START_CODE, 8'h5A);
        write_reg(REG_STOP_CODE, 8'h00);
        add_random(20);
        settle_idle();

        // receiver holds off while the sender keeps pushing
        write_reg(REG_ACK_CODE, 8'hFF);
        write_reg(REG_START_CODE, 8'h00);
        write_reg(REG_STOP_CODE, 8'hFF);
        hold_requests++;
        add_random(70);

        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bfr_pkg.sv
src/bfr_store.sv
src/bfr_emit.sv
src/bus_frame_receiver_unit.sv
verif/tb.sv
